@@ sv/i2csbe_pkg.sv @@
// ----------------------------------------------------------------------------
// I2C slave buffer engine package
// Operation and response codes plus field widths shared by the engine and its testbench.
// ----------------------------------------------------------------------------
package i2csbe_pkg;

  localparam int OP_W    = 4;
  localparam int BYTE_W  = 8;
  localparam int INDEX_W = 7;
  localparam int COUNT_W = 8;
  localparam int RESP_W  = 2;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 40;

  // Saturation value of the shared transfer pointer.
  localparam logic [INDEX_W-1:0] PTR_MAX = '1;

  typedef enum logic [OP_W-1:0] {
    OP_ADDR_WRITE = 4'd0,
    OP_RX_ACK     = 4'd1,
    OP_RX_NACK    = 4'd2,
    OP_STOP       = 4'd3,
    OP_ADDR_READ  = 4'd4,
    OP_TX_ACK     = 4'd5,
    OP_TX_NACK    = 4'd6,
    OP_LAST_TX    = 4'd7,
    OP_ERROR      = 4'd8,
    OP_HOST_WR    = 4'd9,
    OP_HOST_COUNT = 4'd10,
    OP_HOST_RD    = 4'd11
  } op_t;

  typedef enum logic [RESP_W-1:0] {
    RESP_ACK  = 2'd0,
    RESP_NACK = 2'd1,
    RESP_STOP = 2'd2,
    RESP_NONE = 2'd3
  } resp_t;

endpackage

@@ sv/i2csbe_ram.sv @@
// ----------------------------------------------------------------------------
// I2C slave buffer engine RAM
// Generic single write port, single read port memory with registered read.
// ----------------------------------------------------------------------------
module i2csbe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ sv/i2c_slave_buffer_engine_top.sv @@
// ----------------------------------------------------------------------------
// I2C slave buffer engine
// Answers address-matched bus events and host accesses for an I2C slave,
// buffering received bytes and bytes pending to send.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                      Contents
//  s_axis    in         s_axis_tvalid / s_axis_tready  tuser op, tdata payload
//  m_axis    out        m_axis_tvalid / m_axis_tready  tdata result
//  cfg       in         cfg_we                         cfg_wdata idle fill byte
//
// One request is accepted per clock cycle while s_axis_tready is high; its
// result passes through the registered read port of the receive and send
// store RAMs, alongside the middle stage, and then the result register.
// All bookkeeping state (pointer, counts, entry valid bits) is updated at the
// accept edge, so requests may follow each other back to back.
// Reset clears the control state and the store valid bits at once; an entry
// that was never written reads as zero. There is no clearing pass, and
// s_axis_tready stays low while reset is asserted.
// A stalled result holds in the output register while one more request sits
// in the middle stage; only then does s_axis_tready drop.
// ----------------------------------------------------------------------------
module i2c_slave_buffer_engine_top #(
  parameter int RECV_DEPTH = 32,
  parameter int SEND_DEPTH = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  // s_axis_tuser: op[3:0]
  // s_axis_tdata: bus_byte[7:0], entry_index[14:8], send_count_value[22:15],
  //               zero fill[23]
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [i2csbe_pkg::OP_W-1:0]         s_axis_tuser,
  input  logic [i2csbe_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // m_axis_tdata: line_response[1:0], tx_byte[9:2], received_count[16:10],
  //               pending_send_count[24:17], host_read_data[32:25],
  //               zero fill[39:33]
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [i2csbe_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // Idle fill byte register
  input  logic                                cfg_we,
  input  logic [i2csbe_pkg::BYTE_W-1:0]       cfg_wdata
);

  import i2csbe_pkg::*;

  localparam int RAW = (RECV_DEPTH > 1) ? $clog2(RECV_DEPTH) : 1;
  localparam int SAW = (SEND_DEPTH > 1) ? $clog2(SEND_DEPTH) : 1;
  localparam logic [INDEX_W-1:0] RD7    = INDEX_W'(RECV_DEPTH);
  localparam logic [INDEX_W-1:0] RD7_M1 = INDEX_W'(RECV_DEPTH - 1);
  localparam logic [INDEX_W-1:0] SD7    = INDEX_W'(SEND_DEPTH);
  localparam logic [COUNT_W-1:0] SD8    = COUNT_W'(SEND_DEPTH);

  // Request fields.
  op_t                s_op;
  logic [BYTE_W-1:0]  s_byte;
  logic [INDEX_W-1:0] s_index;
  logic [COUNT_W-1:0] s_count;

  assign s_op    = op_t'(s_axis_tuser);
  assign s_byte  = s_axis_tdata[7:0];
  assign s_index = s_axis_tdata[14:8];
  assign s_count = s_axis_tdata[22:15];

  // Architectural state.
  logic [INDEX_W-1:0]    ptr;
  logic [INDEX_W-1:0]    ptr_next;
  logic [INDEX_W-1:0]    rcnt;
  logic [INDEX_W-1:0]    rcnt_next;
  logic [COUNT_W-1:0]    scnt;
  logic [COUNT_W-1:0]    scnt_next;
  logic [BYTE_W-1:0]     fill;
  logic [RECV_DEPTH-1:0] recv_valid;
  logic [SEND_DEPTH-1:0] send_valid;

  // Middle stage: waits for the registered RAM read.
  logic               s1_valid;
  resp_t              s1_resp;
  logic [BYTE_W-1:0]  s1_tx_pre;
  logic               s1_tx_use;
  logic               s1_hrd_use;
  logic [INDEX_W-1:0] s1_rcnt;
  logic [COUNT_W-1:0] s1_scnt;

  // Output register.
  logic                  out_valid;
  logic [OUT_DATA_W-1:0] out_data;

  logic s_accept;
  logic s1_move;

  assign s1_move       = s1_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !rst && (!s1_valid || s1_move);
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  // Store addressing. The receive store is written at the pointer and read by
  // the host index; the send store is the other way around.
  logic [INDEX_W-1:0] ptr_inc;
  logic [INDEX_W-1:0] send_rptr;
  logic [RAW-1:0]     recv_waddr;
  logic [RAW-1:0]     recv_raddr;
  logic [SAW-1:0]     send_waddr;
  logic [SAW-1:0]     send_raddr;
  logic               recv_we;
  logic               send_we;
  logic [BYTE_W-1:0]  recv_rdata;
  logic [BYTE_W-1:0]  send_rdata;
  logic [COUNT_W-1:0] scnt_clamp;

  assign ptr_inc    = (ptr == PTR_MAX) ? ptr : ptr + INDEX_W'(1);
  assign send_rptr  = (s_op == OP_ADDR_READ) ? '0 : ptr;
  assign recv_waddr = ptr[RAW-1:0];
  assign recv_raddr = s_index[RAW-1:0];
  assign send_waddr = s_index[SAW-1:0];
  assign send_raddr = send_rptr[SAW-1:0];
  assign scnt_clamp = (scnt > SD8) ? SD8 : scnt;

  assign recv_we = s_accept && ((s_op == OP_RX_ACK) || (s_op == OP_RX_NACK)) && (ptr < RD7);
  assign send_we = s_accept && (s_op == OP_HOST_WR) && (s_index < SD7);

  // Per-request decision logic; nothing here depends on store contents.
  resp_t             resp;
  logic [BYTE_W-1:0] tx_pre;
  logic              tx_use;
  logic              hrd_use;
  logic              send_hit;

  // A send read returns RAM data only for a written entry inside the store.
  assign send_hit = (send_rptr < SD7) && send_valid[send_raddr];

  always_comb begin
    ptr_next  = ptr;
    rcnt_next = rcnt;
    scnt_next = scnt;
    resp      = RESP_STOP;
    tx_pre    = '0;
    tx_use    = 1'b0;
    hrd_use   = 1'b0;
    case (s_op)
      OP_ADDR_WRITE: begin
        ptr_next  = '0;
        rcnt_next = '0;
        resp      = RESP_ACK;
      end
      OP_RX_ACK: begin
        ptr_next = ptr_inc;
        // Nack ahead of the final free slot.
        resp     = (ptr_inc < RD7_M1) ? RESP_ACK : RESP_NACK;
      end
      OP_RX_NACK: begin
        ptr_next  = ptr_inc;
        rcnt_next = (ptr_inc < RD7) ? ptr_inc : RD7;
        resp      = RESP_ACK;
      end
      OP_STOP: begin
        rcnt_next = (ptr < RD7) ? ptr : RD7;
        resp      = RESP_ACK;
      end
      OP_ADDR_READ: begin
        if (scnt == '0) begin
          // Nothing pending: send the fill byte and nack.
          tx_pre = fill;
          resp   = RESP_NACK;
        end else begin
          scnt_next = scnt_clamp;
          ptr_next  = INDEX_W'(1);
          tx_use    = send_hit;
          resp      = (COUNT_W'(1) < scnt_clamp) ? RESP_ACK : RESP_NACK;
        end
      end
      OP_TX_ACK: begin
        ptr_next = ptr_inc;
        tx_use   = send_hit;
        resp     = ({1'b0, ptr_inc} < scnt) ? RESP_ACK : RESP_NACK;
      end
      OP_TX_NACK, OP_LAST_TX: begin
        scnt_next = '0;
        resp      = RESP_ACK;
      end
      OP_HOST_WR: begin
        resp = RESP_NONE;
      end
      OP_HOST_COUNT: begin
        scnt_next = s_count;
        resp      = RESP_NONE;
      end
      OP_HOST_RD: begin
        hrd_use = (s_index < RD7) && recv_valid[recv_raddr];
        resp    = RESP_NONE;
      end
      default: begin
        resp = RESP_STOP;
      end
    endcase
  end

  i2csbe_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (RECV_DEPTH)
  ) u_recv_ram (
    .clk   (clk),
    .we    (recv_we),
    .waddr (recv_waddr),
    .wdata (s_byte),
    .re    (s_accept),
    .raddr (recv_raddr),
    .rdata (recv_rdata)
  );

  i2csbe_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (SEND_DEPTH)
  ) u_send_ram (
    .clk   (clk),
    .we    (send_we),
    .waddr (send_waddr),
    .wdata (s_byte),
    .re    (s_accept),
    .raddr (send_raddr),
    .rdata (send_rdata)
  );

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr        <= '0;
      rcnt       <= '0;
      scnt       <= '0;
      fill       <= '1;
      recv_valid <= '0;
      send_valid <= '0;
      s1_valid   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        fill <= cfg_wdata;
      end
      if (s_accept) begin
        ptr  <= ptr_next;
        rcnt <= rcnt_next;
        scnt <= scnt_next;
      end
      if (recv_we) begin
        recv_valid[recv_waddr] <= 1'b1;
      end
      if (send_we) begin
        send_valid[send_waddr] <= 1'b1;
      end
      if (s_accept) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  logic [BYTE_W-1:0] tx_final;
  logic [BYTE_W-1:0] hrd_final;

  assign tx_final  = s1_tx_use ? send_rdata : s1_tx_pre;
  assign hrd_final = s1_hrd_use ? recv_rdata : '0;

  always_ff @(posedge clk) begin
    if (s_accept) begin
      s1_resp    <= resp;
      s1_tx_pre  <= tx_pre;
      s1_tx_use  <= tx_use;
      s1_hrd_use <= hrd_use;
      s1_rcnt    <= rcnt_next;
      s1_scnt    <= scnt_next;
    end
    if (s1_move) begin
      out_data <= {7'd0, hrd_final, s1_scnt, s1_rcnt, tx_final, s1_resp};
    end
  end

  // A host count request leaves exactly its value as the pending count.
  a_host_count: assert property (@(posedge clk) disable iff (rst)
    (s_accept && (s_op == OP_HOST_COUNT)) |=> (scnt == $past(s_count)))
    else $error("pending count not taken from host count request");

  // An address read with data pending leaves a nonzero count within the store.
  a_send_clamp: assert property (@(posedge clk) disable iff (rst)
    (s_accept && (s_op == OP_ADDR_READ) && (scnt != '0))
      |=> ((scnt <= SD8) && (scnt != '0) && (ptr == INDEX_W'(1))))
    else $error("send count not clamped on address read");

  // The recorded receive count never exceeds the store depth.
  a_rcnt_range: assert property (@(posedge clk) disable iff (rst)
    s_accept |=> (rcnt <= RD7) && s1_valid)
    else $error("receive count beyond store depth");

  // A request that cannot leave the middle stage keeps its decision.
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_move) |=> (s1_valid && $stable(s1_resp) && $stable(s1_tx_use)))
    else $error("middle stage lost a stalled request");

endmodule

@@ dv/tb_i2c_slave_buffer_engine_top.sv @@
// ----------------------------------------------------------------------------
// Testbench for the I2C slave buffer engine
// Drives bus events and host accesses as requests on the input stream. Every
// accepted request is run through a predictor of the engine in this file, and
// each result on the output stream is compared field by field with the oldest
// prediction. A short table of directed requests comes first. Randomized write
// transfers, read transfers, host accesses and noise follow over several idle
// fill byte settings, with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_i2c_slave_buffer_engine_top;
  import i2csbe_pkg::*;

  localparam int RECV_DEPTH = 32;
  localparam int SEND_DEPTH = 32;
  localparam int RX_AW      = $clog2(RECV_DEPTH);
  localparam int TX_AW      = $clog2(SEND_DEPTH);

  // The op field is four bits wide. Codes 12 to 15 are unused and must be
  // answered with stop, like the error event.
  localparam logic [OP_W-1:0] OP_SPARE_FIRST = 4'd12;
  localparam logic [OP_W-1:0] OP_SPARE_LAST  = 4'd15;

  // Random part: number of phases and requests per phase.
  localparam int PHASES         = 10;
  localparam int PHASE_REQUESTS = 110;
  // Phase with no idling on either side.
  localparam int CALM_PHASE     = 4;
  // Cycles to let pass after the last expected result has arrived.
  localparam int SETTLE_CYCLES  = 8;
  // Hard limit on the run in time units; a correct run needs far less.
  localparam int RUN_LIMIT      = 2_000_000;
  localparam int MAX_REPORTS    = 10;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [BYTE_W-1:0]  data;
    logic [INDEX_W-1:0] idx;
    logic [COUNT_W-1:0] cnt;
  } bus_req_t;

  typedef struct packed {
    resp_t              resp;
    logic [BYTE_W-1:0]  tx;
    logic [INDEX_W-1:0] rcnt;
    logic [COUNT_W-1:0] pend;
    logic [BYTE_W-1:0]  hrd;
  } engine_out_t;

  // A directed row may carry a result typed in by hand; otherwise the
  // predictor supplies it.
  typedef struct packed {
    bus_req_t    req;
    logic        typed;
    engine_out_t want;
  } directed_row_t;

  // --------------------------------------------------------------------------
  // Clock, reset and the signals of the block.
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst = 1'b1;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [OP_W-1:0]       s_axis_tuser  = '0;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b1;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_we        = 1'b0;
  logic [BYTE_W-1:0]     cfg_wdata     = '0;

  i2c_slave_buffer_engine_top #(
    .RECV_DEPTH(RECV_DEPTH),
    .SEND_DEPTH(SEND_DEPTH)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata)
  );

  // --------------------------------------------------------------------------
  // Predictor state: a private copy of everything the engine remembers.
  // --------------------------------------------------------------------------
  logic [INDEX_W-1:0] xfer_ptr;
  logic [BYTE_W-1:0]  rx_mem [RECV_DEPTH];
  logic [BYTE_W-1:0]  tx_mem [SEND_DEPTH];
  logic [INDEX_W-1:0] rx_count;
  logic [COUNT_W-1:0] tx_pending;
  logic [BYTE_W-1:0]  fill_byte;

  engine_out_t   expected_q [$];
  directed_row_t directed_tab [$];

  // When set, neither side idles.
  bit calm = 1'b0;

  int fail_count   = 0;
  int results_seen = 0;
  int req_sent     = 0;
  int cfg_writes   = 0;
  int directed_cnt = 0;

  // The shared pointer saturates instead of wrapping.
  function automatic void bump_ptr();
    if (xfer_ptr != PTR_MAX) xfer_ptr = xfer_ptr + 1'b1;
  endfunction

  // A received byte beyond the store is dropped, but the pointer still moves.
  function automatic void take_byte(input logic [BYTE_W-1:0] b);
    if (xfer_ptr < RECV_DEPTH) rx_mem[xfer_ptr[RX_AW-1:0]] = b;
    bump_ptr();
  endfunction

  // The recorded count is the pointer clamped to the store depth.
  function automatic void record_count();
    rx_count = (xfer_ptr < RECV_DEPTH) ? xfer_ptr : INDEX_W'(RECV_DEPTH);
  endfunction

  // Sends the byte under the pointer; the last pending byte is nacked.
  function automatic resp_t send_next(output logic [BYTE_W-1:0] tx);
    tx = (xfer_ptr < SEND_DEPTH) ? tx_mem[xfer_ptr[TX_AW-1:0]] : '0;
    bump_ptr();
    return (COUNT_W'(xfer_ptr) < tx_pending) ? RESP_ACK : RESP_NACK;
  endfunction

  // Updates the predictor state for one accepted request and returns the
  // result the engine must produce for it.
  function automatic engine_out_t engine_predict(input bus_req_t r);
    engine_out_t o;
    logic [BYTE_W-1:0] tx;
    o.resp = RESP_STOP;
    o.tx   = '0;
    o.hrd  = '0;
    tx     = '0;
    case (r.op)
      OP_ADDR_WRITE: begin
        xfer_ptr = '0;
        rx_count = '0;
        o.resp   = RESP_ACK;
      end
      OP_RX_ACK: begin
        take_byte(r.data);
        // The slave nacks ahead of the final free slot.
        o.resp = (xfer_ptr < RECV_DEPTH - 1) ? RESP_ACK : RESP_NACK;
      end
      OP_RX_NACK: begin
        take_byte(r.data);
        record_count();
        o.resp = RESP_ACK;
      end
      OP_STOP: begin
        // Also taken after a read transfer, with the shared pointer.
        record_count();
        o.resp = RESP_ACK;
      end
      OP_ADDR_READ: begin
        if (tx_pending == '0) begin
          o.tx   = fill_byte;
          o.resp = RESP_NACK;
        end else begin
          if (tx_pending > SEND_DEPTH) tx_pending = COUNT_W'(SEND_DEPTH);
          xfer_ptr = '0;
          o.resp   = send_next(tx);
          o.tx     = tx;
        end
      end
      OP_TX_ACK: begin
        o.resp = send_next(tx);
        o.tx   = tx;
      end
      OP_TX_NACK, OP_LAST_TX: begin
        tx_pending = '0;
        o.resp     = RESP_ACK;
      end
      OP_HOST_WR: begin
        if (r.idx < SEND_DEPTH) tx_mem[r.idx[TX_AW-1:0]] = r.data;
        o.resp = RESP_NONE;
      end
      OP_HOST_COUNT: begin
        tx_pending = r.cnt;
        o.resp     = RESP_NONE;
      end
      OP_HOST_RD: begin
        if (r.idx < RECV_DEPTH) o.hrd = rx_mem[r.idx[RX_AW-1:0]];
        o.resp = RESP_NONE;
      end
      default: o.resp = RESP_STOP;
    endcase
    o.rcnt = rx_count;
    o.pend = tx_pending;
    return o;
  endfunction

  // --------------------------------------------------------------------------
  // Request side. A request is presented with tvalid high and is accepted at
  // the first rising edge at which tready is also high. tvalid stays high
  // between back-to-back requests and is lowered only while the sender idles.
  // --------------------------------------------------------------------------
  task automatic send_req(input bus_req_t r, input logic typed, input engine_out_t want);
    engine_out_t p;
    while (!calm && $urandom_range(99) < 16) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= r.op;
    s_axis_tdata  <= {1'b0, r.cnt, r.idx, r.data};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    // The request went in at this edge; the predictor sees it in order.
    p = engine_predict(r);
    expected_q.push_back(typed ? want : p);
    req_sent++;
  endtask

  task automatic issue(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] data,
                       input logic [INDEX_W-1:0] idx, input logic [COUNT_W-1:0] cnt);
    bus_req_t r;
    r.op   = op;
    r.data = data;
    r.idx  = idx;
    r.cnt  = cnt;
    send_req(r, 1'b0, '0);
  endtask

  // Stops sending and waits until every expected result has come out, then
  // lets the pipeline settle. The fill byte is changed only after this drain.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_fill(input logic [BYTE_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    fill_byte  = v;
    cfg_writes++;
  endtask

  task automatic add_row(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] data,
                         input logic [INDEX_W-1:0] idx, input logic [COUNT_W-1:0] cnt,
                         input logic typed, input resp_t resp,
                         input logic [BYTE_W-1:0] tx, input logic [INDEX_W-1:0] rcnt,
                         input logic [COUNT_W-1:0] pend, input logic [BYTE_W-1:0] hrd);
    directed_row_t row;
    row.req.op    = op;
    row.req.data  = data;
    row.req.idx   = idx;
    row.req.cnt   = cnt;
    row.typed     = typed;
    row.want.resp = resp;
    row.want.tx   = tx;
    row.want.rcnt = rcnt;
    row.want.pend = pend;
    row.want.hrd  = hrd;
    directed_tab.push_back(row);
  endtask

  // Mostly indexes inside the stores, sometimes anywhere in the field.
  function automatic logic [INDEX_W-1:0] pick_index();
    if ($urandom_range(99) < 85) return INDEX_W'($urandom_range(RECV_DEPTH - 1));
    return INDEX_W'($urandom_range(127));
  endfunction

  function automatic logic [BYTE_W-1:0] rnd_byte();
    return BYTE_W'($urandom_range(255));
  endfunction

  // A master writing to the slave: address, a run of bytes and an ending.
  // Some runs are broken: no address phase, or no proper ending.
  task automatic write_transfer();
    int n;
    if ($urandom_range(99) >= 10) issue(OP_ADDR_WRITE, rnd_byte(), pick_index(), rnd_byte());
    // Rarely a run far past the store, long enough at times to saturate the pointer.
    n = ($urandom_range(99) < 4) ? $urandom_range(135, 100) : $urandom_range(36);
    repeat (n) issue(OP_RX_ACK, rnd_byte(), pick_index(), rnd_byte());
    case ($urandom_range(3))
      0: begin
        issue(OP_RX_NACK, rnd_byte(), pick_index(), rnd_byte());
        issue(OP_STOP, rnd_byte(), pick_index(), rnd_byte());
      end
      1: issue(OP_STOP, rnd_byte(), pick_index(), rnd_byte());
      2: issue(OP_RX_NACK, rnd_byte(), pick_index(), rnd_byte());
      default: ;
    endcase
  endtask

  // The host loads some send entries and a count, then a master reads.
  task automatic read_transfer();
    int k;
    int m;
    int sel;
    logic [COUNT_W-1:0] cnt;
    k = $urandom_range(4);
    repeat (k) issue(OP_HOST_WR, rnd_byte(), pick_index(), rnd_byte());
    sel = $urandom_range(99);
    if (sel < 15) cnt = '0;
    else if (sel < 30) cnt = rnd_byte();
    else cnt = COUNT_W'($urandom_range(34, 1));
    issue(OP_HOST_COUNT, rnd_byte(), pick_index(), cnt);
    issue(OP_ADDR_READ, rnd_byte(), pick_index(), rnd_byte());
    if ($urandom_range(99) < 4) m = $urandom_range(135, 100);
    else m = $urandom_range(((cnt > 40) ? 40 : int'(cnt)) + 3);
    repeat (m) issue(OP_TX_ACK, rnd_byte(), pick_index(), rnd_byte());
    case ($urandom_range(3))
      0: issue(OP_TX_NACK, rnd_byte(), pick_index(), rnd_byte());
      1: issue(OP_LAST_TX, rnd_byte(), pick_index(), rnd_byte());
      2: issue(OP_STOP, rnd_byte(), pick_index(), rnd_byte());
      default: ;
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Result side. The receiver stalls at random; each accepted result is
  // checked against the oldest prediction.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    engine_out_t got;
    engine_out_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.resp = resp_t'(m_axis_tdata[1:0]);
      got.tx   = m_axis_tdata[9:2];
      got.rcnt = m_axis_tdata[16:10];
      got.pend = m_axis_tdata[24:17];
      got.hrd  = m_axis_tdata[32:25];
      results_seen++;
      if (expected_q.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display({"Result with no request outstanding: ",
                    "resp %0d tx %0h rcnt %0d pend %0d hrd %0h"},
                   got.resp, got.tx, got.rcnt, got.pend, got.hrd);
      end else begin
        want = expected_q.pop_front();
        if (got != want) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display({"Mismatch on result %0d: ",
                      "exp resp %0d tx %0h rcnt %0d pend %0d hrd %0h, ",
                      "got resp %0d tx %0h rcnt %0d pend %0d hrd %0h"},
                     results_seen, want.resp, want.tx, want.rcnt, want.pend, want.hrd,
                     got.resp, got.tx, got.rcnt, got.pend, got.hrd);
        end
      end
    end
    m_axis_tready <= calm || ($urandom_range(99) >= 16);
  end

  // --------------------------------------------------------------------------
  // Main sequence: reset, directed table, random phases, final check.
  // --------------------------------------------------------------------------
  initial begin
    int phase_start;
    int sel;
    xfer_ptr   = '0;
    rx_count   = '0;
    tx_pending = '0;
    fill_byte  = 8'hFF;
    rx_mem     = '{default: '0};
    tx_mem     = '{default: '0};

    // Directed table. Rows with a typed result start from the reset state,
    // hit the extremes of the fields, or give a fixed answer such as stop.
    add_row(OP_HOST_RD,     8'h00, 7'd0,   8'd0,   1, RESP_NONE, 8'h00, 7'd0, 8'd0,   8'h00);
    // Nothing pending: the idle fill byte goes out with nack.
    add_row(OP_ADDR_READ,   8'hFF, 7'd127, 8'd255, 1, RESP_NACK, 8'hFF, 7'd0, 8'd0,   8'h00);
    add_row(OP_ERROR,       8'hFF, 7'd127, 8'd255, 1, RESP_STOP, 8'h00, 7'd0, 8'd0,   8'h00);
    add_row(OP_SPARE_FIRST, 8'hFF, 7'd127, 8'd255, 1, RESP_STOP, 8'h00, 7'd0, 8'd0,   8'h00);
    add_row(OP_SPARE_LAST,  8'hFF, 7'd127, 8'd255, 1, RESP_STOP, 8'h00, 7'd0, 8'd0,   8'h00);
    add_row(OP_HOST_WR,     8'hA5, 7'd0,   8'd0,   1, RESP_NONE, 8'h00, 7'd0, 8'd0,   8'h00);
    // A host write to an index past the send store is ignored.
    add_row(OP_HOST_WR,     8'hFF, 7'd127, 8'd0,   1, RESP_NONE, 8'h00, 7'd0, 8'd0,   8'h00);
    add_row(OP_HOST_WR,     8'h5A, 7'd31,  8'd0,   1, RESP_NONE, 8'h00, 7'd0, 8'd0,   8'h00);
    add_row(OP_HOST_COUNT,  8'h00, 7'd0,   8'd255, 1, RESP_NONE, 8'h00, 7'd0, 8'd255, 8'h00);
    // Read with a count above the store depth: the count is clamped first.
    add_row(OP_ADDR_READ,   8'h00, 7'd0,   8'd0,   0, RESP_ACK,  8'h00, 7'd0, 8'd0,   8'h00);
    add_row(OP_TX_ACK,      8'h00, 7'd0,   8'd0,   0, RESP_ACK,  8'h00, 7'd0, 8'd0,   8'h00);
    // Stop after a read takes the shared pointer as the received count.
    add_row(OP_STOP,        8'h00, 7'd0,   8'd0,   0, RESP_ACK,  8'h00, 7'd0, 8'd0,   8'h00);
    add_row(OP_TX_NACK,     8'h00, 7'd0,   8'd0,   0, RESP_ACK,  8'h00, 7'd0, 8'd0,   8'h00);
    add_row(OP_ADDR_WRITE,  8'h00, 7'd0,   8'd0,   1, RESP_ACK,  8'h00, 7'd0, 8'd0,   8'h00);
    add_row(OP_RX_ACK,      8'h00, 7'd0,   8'd0,   0, RESP_ACK,  8'h00, 7'd0, 8'd0,   8'h00);
    add_row(OP_RX_ACK,      8'hFF, 7'd0,   8'd0,   0, RESP_ACK,  8'h00, 7'd0, 8'd0,   8'h00);
    add_row(OP_RX_NACK,     8'h81, 7'd0,   8'd0,   0, RESP_ACK,  8'h00, 7'd0, 8'd0,   8'h00);
    add_row(OP_HOST_RD,     8'h00, 7'd2,   8'd0,   0, RESP_ACK,  8'h00, 7'd0, 8'd0,   8'h00);
    // A host read past the receive store returns zero.
    add_row(OP_HOST_RD,     8'h00, 7'd127, 8'd0,   0, RESP_ACK,  8'h00, 7'd0, 8'd0,   8'h00);
    add_row(OP_HOST_COUNT,  8'h00, 7'd0,   8'd1,   0, RESP_ACK,  8'h00, 7'd0, 8'd0,   8'h00);
    add_row(OP_ADDR_READ,   8'h00, 7'd0,   8'd0,   0, RESP_ACK,  8'h00, 7'd0, 8'd0,   8'h00);
    // A tx ack with nothing left pending is answered with nack.
    add_row(OP_TX_ACK,      8'h00, 7'd0,   8'd0,   0, RESP_ACK,  8'h00, 7'd0, 8'd0,   8'h00);
    add_row(OP_LAST_TX,     8'h00, 7'd0,   8'd0,   0, RESP_ACK,  8'h00, 7'd0, 8'd0,   8'h00);
    add_row(OP_ERROR,       8'h00, 7'd0,   8'd0,   0, RESP_ACK,  8'h00, 7'd0, 8'd0,   8'h00);

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_tab[i]) send_req(directed_tab[i].req, directed_tab[i].typed,
                                       directed_tab[i].want);
    directed_cnt = req_sent;
    // The sender holds off here until every directed result has been seen.
    wait_drained();

    // Random phases. The fill byte changes between phases, starting with the
    // two extremes; one phase runs with no idling on either side.
    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == 0) write_fill(8'h00);
      else if (ph == 1) write_fill(8'hFF);
      else write_fill(rnd_byte());
      calm = (ph == CALM_PHASE);
      phase_start = req_sent;
      while (req_sent - phase_start < PHASE_REQUESTS) begin
        sel = $urandom_range(99);
        if (sel < 30) write_transfer();
        else if (sel < 60) read_transfer();
        else if (sel < 75) repeat ($urandom_range(4, 1))
          issue(OP_HOST_RD, rnd_byte(), pick_index(), rnd_byte());
        else if (sel < 85) repeat ($urandom_range(4, 1))
          issue(OP_HOST_WR, rnd_byte(), pick_index(), rnd_byte());
        else repeat ($urandom_range(4, 1))
          issue(OP_W'($urandom_range(15)), rnd_byte(), INDEX_W'($urandom_range(127)),
                rnd_byte());
      end
      wait_drained();
      calm = 1'b0;
    end

    $display("Ran %0d requests (%0d directed) under %0d fill byte settings.",
             req_sent, directed_cnt, cfg_writes);
    $display("Checked %0d results; %0d failures, %0d results still outstanding.",
             results_seen, fail_count, expected_q.size());
    if (fail_count == 0 && expected_q.size() == 0) begin
      $display("tb_i2c_slave_buffer_engine_top OK");
    end else begin
      $display("tb_i2c_slave_buffer_engine_top NOT OK");
    end
    $finish;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    #(RUN_LIMIT);
    $display("Run limit reached with %0d results outstanding.", expected_q.size());
    $display("tb_i2c_slave_buffer_engine_top NOT OK");
    $finish;
  end

endmodule
